@@ src/rfr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rfr_pkg;

    // Largest buffer capacity a start accepts
    localparam int MAX_FRAME = 256;

    // Register reset values
    localparam logic [23:0] HEADER_RST   = 24'hDEDFEF;
    localparam logic [7:0]  COMMAND_RST  = 8'h00;
    localparam logic [7:0]  TAIL_RST     = 8'hAA;
    localparam logic [1:0]  END_MODE_RST = 2'd1;
    localparam logic [8:0]  MIN_LEN_RST  = 9'd5;
    localparam logic [8:0]  CAPACITY_RST = 9'd96;
    localparam logic [7:0]  IDLE_GAP_RST = 8'd5;
    localparam logic [15:0] TIMEOUT_RST  = 16'd1000;

    // Register map, word index
    typedef enum logic [2:0] {
        REG_HEADER   = 3'd0,
        REG_COMMAND  = 3'd1,
        REG_TAIL     = 3'd2,
        REG_END_MODE = 3'd3,
        REG_MIN_LEN  = 3'd4,
        REG_CAPACITY = 3'd5,
        REG_IDLE_GAP = 3'd6,
        REG_TIMEOUT  = 3'd7
    } t_reg_idx;

    localparam int APB_AW = 5;

    // Request operations
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2,
        OP_RSVD  = 2'd3
    } t_op;

    // Frame end modes (any code above idle behaves as idle)
    localparam logic [1:0] END_TAIL  = 2'd0;
    localparam logic [1:0] END_EXACT = 2'd1;
    localparam logic [1:0] END_IDLE  = 2'd2;

    typedef struct packed {
        logic [23:0] header_bytes;
        logic [7:0]  command_byte;
        logic [7:0]  tail_byte;
        logic [1:0]  end_mode;
        logic [8:0]  min_length;
        logic [8:0]  buffer_capacity;
        logic [7:0]  idle_gap_ticks;
        logic [15:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic       stored_valid;
        logic [7:0] stored_byte;
        logic [7:0] stored_index;
        logic       done_res;
        logic       success;
        logic [8:0] frame_length;
    } t_result;

    // Expected header byte for a given match stage
    function automatic logic [7:0] header_at(input logic [23:0] hdr, input logic [1:0] stage);
        logic [7:0] b;
        unique case (stage)
            2'd0:    b = hdr[23:16];
            2'd1:    b = hdr[15:8];
            2'd2:    b = hdr[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ src/rfr_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one operation per request
interface rfr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

// Result channel: at most one result per request
interface rfr_out_if;
    logic       valid;
    logic       ready;
    logic       stored_valid;
    logic [7:0] stored_byte;
    logic [7:0] stored_index;
    logic       done_res;
    logic       success;
    logic [8:0] frame_length;

    modport source (output valid, output stored_valid, output stored_byte,
                    output stored_index, output done_res, output success,
                    output frame_length, input ready);
    modport sink   (input valid, input stored_valid, input stored_byte,
                    input stored_index, input done_res, input success,
                    input frame_length, output ready);
endinterface

`default_nettype wire

@@ src/rfr_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rfr_cfg_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [rfr_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output rfr_pkg::t_cfg                   o_cfg
);
    import rfr_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[APB_AW-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_bytes    <= HEADER_RST;
            r_cfg.command_byte    <= COMMAND_RST;
            r_cfg.tail_byte       <= TAIL_RST;
            r_cfg.end_mode        <= END_MODE_RST;
            r_cfg.min_length      <= MIN_LEN_RST;
            r_cfg.buffer_capacity <= CAPACITY_RST;
            r_cfg.idle_gap_ticks  <= IDLE_GAP_RST;
            r_cfg.timeout_ticks   <= TIMEOUT_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_HEADER:   r_cfg.header_bytes    <= pwdata[23:0];
                REG_COMMAND:  r_cfg.command_byte    <= pwdata[7:0];
                REG_TAIL:     r_cfg.tail_byte       <= pwdata[7:0];
                REG_END_MODE: r_cfg.end_mode        <= pwdata[1:0];
                REG_MIN_LEN:  r_cfg.min_length      <= pwdata[8:0];
                REG_CAPACITY: r_cfg.buffer_capacity <= pwdata[8:0];
                REG_IDLE_GAP: r_cfg.idle_gap_ticks  <= pwdata[7:0];
                REG_TIMEOUT:  r_cfg.timeout_ticks   <= pwdata[15:0];
                default:      ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (w_idx)
            REG_HEADER:   prdata = {8'd0, r_cfg.header_bytes};
            REG_COMMAND:  prdata = {24'd0, r_cfg.command_byte};
            REG_TAIL:     prdata = {24'd0, r_cfg.tail_byte};
            REG_END_MODE: prdata = {30'd0, r_cfg.end_mode};
            REG_MIN_LEN:  prdata = {23'd0, r_cfg.min_length};
            REG_CAPACITY: prdata = {23'd0, r_cfg.buffer_capacity};
            REG_IDLE_GAP: prdata = {24'd0, r_cfg.idle_gap_ticks};
            REG_TIMEOUT:  prdata = {16'd0, r_cfg.timeout_ticks};
            default:      prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

@@ src/rfr_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rfr_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire rfr_pkg::t_cfg   i_cfg,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [1:0]      i_operation,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_space,
    output logic                 o_push,
    output rfr_pkg::t_result     o_result
);
    import rfr_pkg::*;

    // Input register
    logic       r_s1_valid;
    t_op        r_op;
    logic [7:0] r_byte;

    // Frame state
    logic        r_armed,     n_armed;
    logic [1:0]  r_stage,     n_stage;
    logic        r_capturing, n_capturing;
    logic [8:0]  r_count,     n_count;
    logic [16:0] r_waited,    n_waited;
    logic [7:0]  r_idle,      n_idle;

    logic    w_go;
    logic    w_emit;
    t_result w_res;

    assign w_go    = r_s1_valid && i_space;
    assign o_ready = !r_s1_valid || i_space;
    assign o_push  = w_go && w_emit;
    assign o_result = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_s1_valid <= 1'b1;
        end else if (w_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op   <= t_op'(i_operation);
            r_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed     <= 1'b0;
            r_stage     <= 2'd0;
            r_capturing <= 1'b0;
            r_count     <= 9'd0;
            r_waited    <= 17'd0;
            r_idle      <= 8'd0;
        end else if (w_go) begin
            r_armed     <= n_armed;
            r_stage     <= n_stage;
            r_capturing <= n_capturing;
            r_count     <= n_count;
            r_waited    <= n_waited;
            r_idle      <= n_idle;
        end
    end

    // Single-pass step of the registered request
    always_comb begin
        logic [8:0] cnt_inc;
        logic       match;
        logic       idle_done;
        logic       bad_cap;

        n_armed     = r_armed;
        n_stage     = r_stage;
        n_capturing = r_capturing;
        n_count     = r_count;
        n_waited    = r_waited;
        n_idle      = r_idle;
        w_emit      = 1'b0;
        w_res       = '0;

        cnt_inc   = r_count + 9'd1;
        idle_done = 1'b0;
        match     = (r_stage == 2'd3) ? (r_byte == i_cfg.command_byte)
                                      : (r_byte == header_at(i_cfg.header_bytes, r_stage));
        bad_cap   = (i_cfg.buffer_capacity == 9'd0)
                 || (int'(i_cfg.buffer_capacity) > MAX_FRAME)
                 || (i_cfg.buffer_capacity < i_cfg.min_length);

        unique case (r_op)
            OP_START: begin
                n_stage     = 2'd0;
                n_capturing = 1'b0;
                n_count     = 9'd0;
                n_waited    = 17'd0;
                n_idle      = 8'd0;
                if (bad_cap) begin
                    n_armed        = 1'b0;
                    w_emit         = 1'b1;
                    w_res.done_res = 1'b1;
                end else begin
                    n_armed = 1'b1;
                end
            end

            OP_TICK: begin
                if (r_armed) begin
                    if (r_waited != '1) n_waited = r_waited + 17'd1;
                    // idle gap counting once the frame is long enough
                    if (r_capturing && (i_cfg.end_mode >= END_IDLE)
                        && (r_count >= i_cfg.min_length)) begin
                        if (r_idle != '1) n_idle = r_idle + 8'd1;
                        idle_done = (n_idle >= i_cfg.idle_gap_ticks);
                    end
                    if (idle_done) begin
                        n_armed            = 1'b0;
                        w_emit             = 1'b1;
                        w_res.done_res     = 1'b1;
                        w_res.success      = 1'b1;
                        w_res.frame_length = r_count;
                    end else if (n_waited > {1'b0, i_cfg.timeout_ticks}) begin
                        n_armed        = 1'b0;
                        w_emit         = 1'b1;
                        w_res.done_res = 1'b1;
                    end
                end
            end

            OP_BYTE: begin
                if (r_armed) begin
                    n_idle = 8'd0;
                    if (!r_capturing) begin
                        if (match) begin
                            if (r_count >= i_cfg.buffer_capacity) begin
                                // overflow
                                n_armed        = 1'b0;
                                w_emit         = 1'b1;
                                w_res.done_res = 1'b1;
                            end else begin
                                n_count            = cnt_inc;
                                w_emit             = 1'b1;
                                w_res.stored_valid = 1'b1;
                                w_res.stored_byte  = r_byte;
                                w_res.stored_index = r_count[7:0];
                                if (r_stage != 2'd3) begin
                                    n_stage = r_stage + 2'd1;
                                end else begin
                                    n_capturing = 1'b1;
                                    if ((i_cfg.end_mode == END_EXACT)
                                        && (cnt_inc >= i_cfg.min_length)) begin
                                        n_armed            = 1'b0;
                                        w_res.done_res     = 1'b1;
                                        w_res.success      = 1'b1;
                                        w_res.frame_length = cnt_inc;
                                    end
                                end
                            end
                        end else if (r_byte == i_cfg.header_bytes[23:16]) begin
                            // resync on first header byte
                            n_stage            = 2'd1;
                            n_count            = 9'd1;
                            w_emit             = 1'b1;
                            w_res.stored_valid = 1'b1;
                            w_res.stored_byte  = r_byte;
                        end else begin
                            n_stage = 2'd0;
                            n_count = 9'd0;
                        end
                    end else if (r_count >= i_cfg.buffer_capacity) begin
                        n_armed        = 1'b0;
                        w_emit         = 1'b1;
                        w_res.done_res = 1'b1;
                    end else begin
                        n_count            = cnt_inc;
                        w_emit             = 1'b1;
                        w_res.stored_valid = 1'b1;
                        w_res.stored_byte  = r_byte;
                        w_res.stored_index = r_count[7:0];
                        if (i_cfg.end_mode == END_TAIL) begin
                            if (r_byte == i_cfg.tail_byte) begin
                                n_armed            = 1'b0;
                                w_res.done_res     = 1'b1;
                                w_res.success      = (cnt_inc >= i_cfg.min_length);
                                w_res.frame_length = cnt_inc;
                            end
                        end else if ((i_cfg.end_mode == END_EXACT)
                                     && (cnt_inc >= i_cfg.min_length)) begin
                            n_armed            = 1'b0;
                            w_res.done_res     = 1'b1;
                            w_res.success      = 1'b1;
                            w_res.frame_length = cnt_inc;
                        end
                    end
                end
            end

            default: ;
        endcase
    end

endmodule

`default_nettype wire

@@ src/rfr_out_buf.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rfr_out_buf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire rfr_pkg::t_result i_result,
    output logic                  o_space,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output rfr_pkg::t_result      o_result
);
    import rfr_pkg::*;

    // Two-entry result buffer; space does not depend on the sink ready
    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_pop;

    assign o_space  = (r_count != 2'd2);
    assign o_valid  = (r_count != 2'd0);
    assign o_result = r_mem[r_rd_ptr];
    assign w_pop    = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= !r_wr_ptr;
            if (w_pop)  r_rd_ptr <= !r_rd_ptr;
            unique case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_result;
    end

endmodule

`default_nettype wire

@@ src/response_frame_receiver_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Response frame receiver: header-synchronized deframer for a UART byte stream.
// Request channel i_req carries an operation (start, byte received, idle tick)
// and a data byte. Result channel o_rsp returns at most one result per request:
// a stored byte with its buffer index, and/or a done flag with success and
// frame length. Requests that produce nothing (ignored bytes, plain ticks,
// a good start) return no result.
// The input register holds each accepted request while it is stepped; its result
// is written into the result buffer and is visible on o_rsp from there.
// Throughput: one request per cycle while the result buffer has space; the
// input register and a two-entry result buffer decouple the channels.
// When the receiver stalls, the result buffer fills, then the input register
// holds its request and i_req.ready drops until space frees up.
// Reset (i_rst_n low, synchronous) disarms the receiver, clears the frame
// progress and buffer, and loads register defaults.
// Registers sit on the APB port at byte address 4*index; write only while idle.

module response_frame_receiver_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    rfr_in_if.sink                          i_req,
    rfr_out_if.source                       o_rsp,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [rfr_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import rfr_pkg::*;

    t_cfg    w_cfg;
    logic    w_space;
    logic    w_push;
    t_result w_res;
    t_result w_out;

    rfr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rfr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (i_req.valid),
        .o_ready     (i_req.ready),
        .i_operation (i_req.operation),
        .i_data_byte (i_req.data_byte),
        .i_space     (w_space),
        .o_push      (w_push),
        .o_result    (w_res)
    );

    rfr_out_buf u_obuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_result (w_res),
        .o_space  (w_space),
        .o_valid  (o_rsp.valid),
        .i_ready  (o_rsp.ready),
        .o_result (w_out)
    );

    assign o_rsp.stored_valid = w_out.stored_valid;
    assign o_rsp.stored_byte  = w_out.stored_byte;
    assign o_rsp.stored_index = w_out.stored_index;
    assign o_rsp.done_res     = w_out.done_res;
    assign o_rsp.success      = w_out.success;
    assign o_rsp.frame_length = w_out.frame_length;

endmodule

`default_nettype wire
